// ----- rtl/wbaa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wbaa_pkg
// Shared types and constants of the weighted bin average accumulator.
// ----------------------------------------------------------------------------
package wbaa_pkg;

    localparam int BIN_COUNT = 1024;
    localparam int ADDR_W    = $clog2(BIN_COUNT);

    localparam int BIN_W    = 10;
    localparam int VALUE_W  = 16;
    localparam int WEIGHT_W = 16;
    localparam int COUNT_W  = 11;
    localparam int PROD_W   = 32;
    localparam int SUM_W    = 48;
    localparam int TOTAL_W  = 32;

    // Quotient magnitude bits kept before saturation to a signed 16-bit mean.
    localparam int QUOT_W     = VALUE_W - 1;
    localparam int DIV_STEPS  = QUOT_W + 1;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef enum logic
    {
        OP_ACC  = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                        op;
        logic [BIN_W-1:0]           bin;
        logic                       in_range;
        logic [WEIGHT_W-1:0]        weight;
        logic signed [PROD_W-1:0]   product;
    } item_t;

    typedef struct packed
    {
        logic                       start;
        logic signed [SUM_W-1:0]    dividend;
        logic [TOTAL_W-1:0]         divisor;
    } div_req_t;

    typedef struct packed
    {
        logic                       done;
        logic signed [VALUE_W-1:0]  quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/wbaa_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wbaa_front
// Accepts input items, classifies them and forms the weighted product.
// ----------------------------------------------------------------------------
module wbaa_front
(
    input  wire logic                                   sample_valid,
    output logic                                        sample_ready,
    input  wire logic                                   command,
    input  wire logic [wbaa_pkg::BIN_W-1:0]             bin_id,
    input  wire logic signed [wbaa_pkg::VALUE_W-1:0]    sample_value,
    input  wire logic [wbaa_pkg::WEIGHT_W-1:0]          sample_weight,
    input  wire logic                                   queue_full,
    input  wire logic                                   clear_done,
    output logic                                        push,
    output wbaa_pkg::item_t                             item
);

    logic signed [wbaa_pkg::PROD_W:0] prod_wide;

    // The product of a Q8.8 value and a Q8.8 weight always fits 32 bits signed.
    assign prod_wide = (wbaa_pkg::PROD_W + 1)'(sample_value) * $signed({1'b0, sample_weight});

    assign sample_ready = clear_done && !queue_full;
    assign push         = sample_valid && sample_ready;

    always_comb
    begin
        item.op       = command ? wbaa_pkg::OP_READ : wbaa_pkg::OP_ACC;
        item.bin      = bin_id;
        item.in_range = (32'(bin_id) < wbaa_pkg::BIN_COUNT);
        item.weight   = sample_weight;
        item.product  = prod_wide[wbaa_pkg::PROD_W-1:0];
    end

endmodule
`default_nettype wire

// ----- rtl/wbaa_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wbaa_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module wbaa_queue
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire wbaa_pkg::item_t    push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    head_valid,
    output wbaa_pkg::item_t         head_item
);

    wbaa_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/wbaa_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wbaa_div
// Iterative restoring divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module wbaa_div
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire wbaa_pkg::div_req_t     req,
    output wbaa_pkg::div_rsp_t          rsp
);

    localparam int SW = wbaa_pkg::SUM_W;
    localparam int QW = wbaa_pkg::QUOT_W;

    logic                               busy_reg;
    logic [wbaa_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [SW-1:0]                      rem_reg;
    logic [SW-1:0]                      dvs_reg;
    logic [QW-1:0]                      quot_reg;
    logic                               neg_reg;
    logic                               done_reg;
    logic signed [wbaa_pkg::VALUE_W-1:0] result_reg;

    logic           ge;
    logic [QW-1:0]  quot_next;
    logic [SW-1:0]  dividend_mag;
    logic           first_step;
    logic           last_step;

    assign ge           = (rem_reg >= dvs_reg);
    assign quot_next    = {quot_reg[QW-2:0], ge};
    assign dividend_mag = req.dividend[SW-1] ? SW'(-req.dividend) : SW'(req.dividend);
    assign first_step   = (cnt_reg == wbaa_pkg::DIV_CNT_W'(wbaa_pkg::DIV_STEPS - 1));
    assign last_step    = busy_reg && !req.start && ((first_step && ge) || (cnt_reg == '0));

    assign rsp.done     = done_reg;
    assign rsp.quotient = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
            rem_reg    <= '0;
            dvs_reg    <= '0;
            quot_reg   <= '0;
            neg_reg    <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= last_step;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= wbaa_pkg::DIV_CNT_W'(wbaa_pkg::DIV_STEPS - 1);
                rem_reg  <= dividend_mag;
                // The first step compares against the divisor scaled by 2^15,
                // which detects a quotient too large for the mean.
                dvs_reg  <= SW'({req.divisor, QW'(0)});
                quot_reg <= '0;
                neg_reg  <= req.dividend[SW-1];
            end
            else if (busy_reg)
            begin
                if (ge)
                begin
                    rem_reg <= rem_reg - dvs_reg;
                end
                dvs_reg  <= dvs_reg >> 1;
                quot_reg <= quot_next;
                cnt_reg  <= cnt_reg - 1'b1;
                if (first_step && ge)
                begin
                    busy_reg   <= 1'b0;
                    result_reg <= neg_reg ? {1'b1, QW'(0)} : {1'b0, {QW{1'b1}}};
                end
                else if (cnt_reg == '0)
                begin
                    busy_reg   <= 1'b0;
                    result_reg <= neg_reg ? -$signed({1'b0, quot_next})
                                          : $signed({1'b0, quot_next});
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/wbaa_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wbaa_back
// Carries out queued items against the bin table and holds the result.
// ----------------------------------------------------------------------------
module wbaa_back
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   head_valid,
    input  wire wbaa_pkg::item_t                        head_item,
    output logic                                        pop,
    output logic                                        clear_done,
    output wbaa_pkg::div_req_t                          div_req,
    input  wire wbaa_pkg::div_rsp_t                     div_rsp,
    output logic                                        result_valid,
    input  wire logic                                   result_ready,
    output logic [wbaa_pkg::BIN_W-1:0]                  read_bin,
    output logic signed [wbaa_pkg::VALUE_W-1:0]         mean_value,
    output logic                                        bin_empty,
    output logic [wbaa_pkg::COUNT_W-1:0]                bins_in_use
);

    localparam int SW = wbaa_pkg::SUM_W;
    localparam int TW = wbaa_pkg::TOTAL_W;
    localparam int AW = wbaa_pkg::ADDR_W;

    typedef struct packed
    {
        logic signed [SW-1:0]   sum;
        logic [TW-1:0]          total;
    } entry_t;

    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_ACC,
        S_RD,
        S_DIV,
        S_OUT
    } state_t;

    state_t                                 state_reg;
    logic [AW-1:0]                          clr_cnt_reg;
    wbaa_pkg::item_t                        item_reg;
    logic [wbaa_pkg::COUNT_W-1:0]           used_reg;
    logic signed [wbaa_pkg::VALUE_W-1:0]    mean_reg;
    logic                                   empty_reg;
    logic                                   out_valid_reg;
    logic [wbaa_pkg::BIN_W-1:0]             out_bin_reg;
    logic signed [wbaa_pkg::VALUE_W-1:0]    out_mean_reg;
    logic                                   out_empty_reg;
    logic [wbaa_pkg::COUNT_W-1:0]           out_used_reg;

    entry_t         mem [wbaa_pkg::BIN_COUNT];
    entry_t         rd_data_reg;
    logic           mem_wr_en;
    logic [AW-1:0]  mem_wr_addr;
    entry_t         mem_wr_data;
    entry_t         acc_entry;

    logic signed [SW:0]             sum_ext;
    logic [TW:0]                    total_ext;
    logic [wbaa_pkg::COUNT_W-1:0]   bin_plus_one;
    logic                           bin_has_weight;
    logic                           out_free;

    assign pop        = (state_reg == S_IDLE) && head_valid;
    assign clear_done = (state_reg != S_CLEAR);
    assign out_free   = !out_valid_reg || result_ready;

    assign bin_plus_one   = wbaa_pkg::COUNT_W'(head_item.bin) + 1'b1;
    assign bin_has_weight = item_reg.in_range && (rd_data_reg.total != '0);

    // Read-modify-write update with independent saturation of sum and total.
    always_comb
    begin
        sum_ext   = (SW + 1)'(rd_data_reg.sum) + (SW + 1)'(item_reg.product);
        total_ext = {1'b0, rd_data_reg.total} + (TW + 1)'(item_reg.weight);
        if (sum_ext[SW] != sum_ext[SW-1])
        begin
            acc_entry.sum = sum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
        else
        begin
            acc_entry.sum = sum_ext[SW-1:0];
        end
        acc_entry.total = total_ext[TW] ? {TW{1'b1}} : total_ext[TW-1:0];
    end

    always_comb
    begin
        mem_wr_en   = (state_reg == S_CLEAR) || ((state_reg == S_ACC) && item_reg.in_range);
        mem_wr_addr = (state_reg == S_CLEAR) ? clr_cnt_reg : item_reg.bin[AW-1:0];
        mem_wr_data = (state_reg == S_CLEAR) ? entry_t'('0) : acc_entry;
    end

    always_comb
    begin
        div_req.start    = (state_reg == S_RD) && bin_has_weight;
        div_req.dividend = rd_data_reg.sum;
        div_req.divisor  = rd_data_reg.total;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (pop)
        begin
            rd_data_reg <= mem[head_item.bin[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            item_reg      <= '0;
            used_reg      <= '0;
            mean_reg      <= '0;
            empty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_bin_reg   <= '0;
            out_mean_reg  <= '0;
            out_empty_reg <= 1'b0;
            out_used_reg  <= '0;
        end
        else
        begin
            // In S_OUT the output register is reloaded below instead.
            if (out_valid_reg && result_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(wbaa_pkg::BIN_COUNT - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (head_valid)
                    begin
                        item_reg <= head_item;
                        if (head_item.op == wbaa_pkg::OP_ACC)
                        begin
                            if (bin_plus_one > used_reg)
                            begin
                                used_reg <= bin_plus_one;
                            end
                            state_reg <= S_ACC;
                        end
                        else
                        begin
                            state_reg <= S_RD;
                        end
                    end
                end
                S_ACC:
                begin
                    state_reg <= S_IDLE;
                end
                S_RD:
                begin
                    if (bin_has_weight)
                    begin
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        mean_reg  <= '0;
                        empty_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        mean_reg  <= div_rsp.quotient;
                        empty_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_bin_reg   <= item_reg.bin;
                        out_mean_reg  <= mean_reg;
                        out_empty_reg <= empty_reg;
                        out_used_reg  <= used_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign read_bin     = out_bin_reg;
    assign mean_value   = out_mean_reg;
    assign bin_empty    = out_empty_reg;
    assign bins_in_use  = out_used_reg;

endmodule
`default_nettype wire

// ----- rtl/weighted_bin_average_accumulator.sv -----
`default_nettype none
// An accumulate holds the back part for a table read, then a saturating write.
// A read holds it for a table read, divider start, 16 divider steps, divider done and
// output load; the divider stops after its first step when the mean saturates, and
// an empty bin skips the divider and goes to the output load. result_valid is
// held back while an earlier result waits for result_ready; a two-entry queue decouples
// the sides. After reset a clearing pass zeroes all 1024 entries with sample_ready low.
// ----------------------------------------------------------------------------
// weighted_bin_average_accumulator
// Per-bin weighted sums and weight totals with a saturated Q8.8 mean readout.
// ----------------------------------------------------------------------------
module weighted_bin_average_accumulator
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   sample_valid,
    output logic                                        sample_ready,
    input  wire logic                                   command,
    input  wire logic [wbaa_pkg::BIN_W-1:0]             bin_id,
    input  wire logic signed [wbaa_pkg::VALUE_W-1:0]    sample_value,
    input  wire logic [wbaa_pkg::WEIGHT_W-1:0]          sample_weight,
    output logic                                        result_valid,
    input  wire logic                                   result_ready,
    output logic [wbaa_pkg::BIN_W-1:0]                  read_bin,
    output logic signed [wbaa_pkg::VALUE_W-1:0]         mean_value,
    output logic                                        bin_empty,
    output logic [wbaa_pkg::COUNT_W-1:0]                bins_in_use
);

    logic                   push;
    wbaa_pkg::item_t        push_item;
    logic                   queue_full;
    logic                   pop;
    logic                   head_valid;
    wbaa_pkg::item_t        head_item;
    logic                   clear_done;
    wbaa_pkg::div_req_t     div_req;
    wbaa_pkg::div_rsp_t     div_rsp;

    wbaa_front u_front
    (
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .command       (command),
        .bin_id        (bin_id),
        .sample_value  (sample_value),
        .sample_weight (sample_weight),
        .queue_full    (queue_full),
        .clear_done    (clear_done),
        .push          (push),
        .item          (push_item)
    );

    wbaa_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    wbaa_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    wbaa_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (pop),
        .clear_done   (clear_done),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .read_bin     (read_bin),
        .mean_value   (mean_value),
        .bin_empty    (bin_empty),
        .bins_in_use  (bins_in_use)
    );

    // No transfer is taken while the table is still being cleared.
    a_no_accept_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_done |-> !sample_ready)
        else $error("input transfer possible during table clear");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !queue_full)
        else $error("queue written while full");

    a_empty_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && bin_empty) |-> (mean_value == '0))
        else $error("empty bin reported with nonzero mean");

    // The divider is started only from the read state of the back part, and its answer is
    // taken while the back part waits for it.
    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> $past(!div_req.start))
        else $error("divider finished in the cycle after a start");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (32'(bins_in_use) <= wbaa_pkg::BIN_COUNT))
        else $error("bins in use beyond table size");

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives accumulate and read transfers into the weighted bin average
// accumulator with random idle cycles on both sides. A scoreboard keeps its
// own copy of the per-bin sums and weight totals and checks every readout.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF     = 5;
    localparam int RANDOM_ITEMS = 1750;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;

    localparam longint SUM_MAX   = (longint'(1) <<< (wbaa_pkg::SUM_W - 1)) - 1;
    localparam longint SUM_MIN   = -SUM_MAX - 1;
    localparam longint TOTAL_MAX = (longint'(1) << wbaa_pkg::TOTAL_W) - 1;
    localparam longint MEAN_MAX  = 32767;
    localparam longint MEAN_MIN  = -32768;

    typedef struct
    {
        logic [wbaa_pkg::BIN_W-1:0]          bin;
        logic signed [wbaa_pkg::VALUE_W-1:0] mean;
        logic                                empty;
        logic [wbaa_pkg::COUNT_W-1:0]        count;
    } bin_readout_t;

    class bin_mean_scoreboard;
        longint       weighted_sums [wbaa_pkg::BIN_COUNT];
        longint       weight_totals [wbaa_pkg::BIN_COUNT];
        int unsigned  used_bins;
        bin_readout_t expected_readouts [$];
        int           errors;
        int           accumulates;
        int           reads;
        int           empty_reads;

        function int pending();
            return expected_readouts.size();
        endfunction

        // Updates the bin tables for an accumulate, or queues the mean that a
        // read must return.
        function void note_transfer(wbaa_pkg::op_t op, logic [wbaa_pkg::BIN_W-1:0] bin,
                                    logic signed [wbaa_pkg::VALUE_W-1:0] value,
                                    logic [wbaa_pkg::WEIGHT_W-1:0] weight);
            longint       v;
            longint       w;
            longint       s;
            longint       t;
            longint       q;
            bin_readout_t r;
            v = value;
            w = weight;
            if (op == wbaa_pkg::OP_ACC)
            begin
                accumulates++;
                if (bin + 1 > used_bins)
                    used_bins = bin + 1;
                s = weighted_sums[bin] + v * w;
                if (s > SUM_MAX)
                    s = SUM_MAX;
                if (s < SUM_MIN)
                    s = SUM_MIN;
                weighted_sums[bin] = s;
                t = weight_totals[bin] + w;
                if (t > TOTAL_MAX)
                    t = TOTAL_MAX;
                weight_totals[bin] = t;
            end
            else
            begin
                reads++;
                r.bin   = bin;
                r.count = wbaa_pkg::COUNT_W'(used_bins);
                if (weight_totals[bin] == 0)
                begin
                    r.mean  = '0;
                    r.empty = 1'b1;
                    empty_reads++;
                end
                else
                begin
                    // Integer division truncates toward zero, as the block does.
                    q = weighted_sums[bin] / weight_totals[bin];
                    if (q > MEAN_MAX)
                        q = MEAN_MAX;
                    if (q < MEAN_MIN)
                        q = MEAN_MIN;
                    r.mean  = q[wbaa_pkg::VALUE_W-1:0];
                    r.empty = 1'b0;
                end
                expected_readouts.insert(expected_readouts.size(), r);
            end
        endfunction

        function void compare_field(string name, logic signed [63:0] expected_val,
                                    logic signed [63:0] actual_val);
            if (actual_val !== expected_val)
            begin
                $display("%0t: %s mismatch: expected %0d actual %0d",
                         $time, name, expected_val, actual_val);
                errors++;
            end
        endfunction

        function void check_readout(logic [wbaa_pkg::BIN_W-1:0] bin,
                                    logic signed [wbaa_pkg::VALUE_W-1:0] mean,
                                    logic empty, logic [wbaa_pkg::COUNT_W-1:0] count);
            bin_readout_t r;
            if (expected_readouts.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual bin %0d mean %0d",
                         $time, bin, mean);
                errors++;
                return;
            end
            r = expected_readouts.pop_front();
            compare_field("read_bin", r.bin, bin);
            compare_field("mean_value", r.mean, mean);
            compare_field("bin_empty", r.empty, empty);
            compare_field("bins_in_use", r.count, count);
        endfunction
    endclass

    logic                                clk;
    logic                                rst_n;
    logic                                sample_valid;
    logic                                sample_ready;
    logic                                command;
    logic [wbaa_pkg::BIN_W-1:0]          bin_id;
    logic signed [wbaa_pkg::VALUE_W-1:0] sample_value;
    logic [wbaa_pkg::WEIGHT_W-1:0]       sample_weight;
    logic                                result_valid;
    logic                                result_ready;
    logic [wbaa_pkg::BIN_W-1:0]          read_bin;
    logic signed [wbaa_pkg::VALUE_W-1:0] mean_value;
    logic                                bin_empty;
    logic [wbaa_pkg::COUNT_W-1:0]        bins_in_use;

    logic                                steady_stretch;
    int                                  cycle_count = 0;
    bin_mean_scoreboard                  sb;

    weighted_bin_average_accumulator uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .command       (command),
        .bin_id        (bin_id),
        .sample_value  (sample_value),
        .sample_weight (sample_weight),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .read_bin      (read_bin),
        .mean_value    (mean_value),
        .bin_empty     (bin_empty),
        .bins_in_use   (bins_in_use)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // Valid stays high across back-to-back transfers; in this task it only drops for a gap.
    task automatic send_item(input wbaa_pkg::op_t op, input logic [wbaa_pkg::BIN_W-1:0] bin,
                             input logic signed [wbaa_pkg::VALUE_W-1:0] value,
                             input logic [wbaa_pkg::WEIGHT_W-1:0] weight);
        int gap;
        gap = steady_stretch ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid  <= 1'b1;
        command       <= op;
        bin_id        <= bin;
        sample_value  <= value;
        sample_weight <= weight;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        sb.note_transfer(op, bin, value, weight);
    endtask

    task automatic wait_for_results();
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = steady_stretch ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            sb.check_readout(read_bin, mean_value, bin_empty, bins_in_use);
        end
    end

    initial
    begin
        int                                  hot_base;
        wbaa_pkg::op_t                       op;
        logic [wbaa_pkg::BIN_W-1:0]          bin;
        logic signed [wbaa_pkg::VALUE_W-1:0] value;
        logic [wbaa_pkg::WEIGHT_W-1:0]       weight;
        clk            = 1'b0;
        rst_n          = 1'b0;
        sample_valid   = 1'b0;
        command        = wbaa_pkg::OP_ACC;
        bin_id         = '0;
        sample_value   = '0;
        sample_weight  = '0;
        result_ready   = 1'b0;
        steady_stretch = 1'b0;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Empty bins at both ends of the table, before anything is in use.
        send_item(wbaa_pkg::OP_READ, 10'd0, 16'sh7FFF, 16'hFFFF);
        send_item(wbaa_pkg::OP_READ, 10'd1023, 16'sh0000, 16'h0000);
        // A zero weight marks the bin as used but leaves it empty.
        send_item(wbaa_pkg::OP_ACC, 10'd5, 16'sh7FFF, 16'h0000);
        send_item(wbaa_pkg::OP_READ, 10'd5, 16'sh0000, 16'h0000);
        // Extreme values at full weight; the mean of -0.5 LSB truncates to zero.
        send_item(wbaa_pkg::OP_ACC, 10'd1023, -16'sd32768, 16'hFFFF);
        send_item(wbaa_pkg::OP_ACC, 10'd1023, 16'sh7FFF, 16'hFFFF);
        send_item(wbaa_pkg::OP_READ, 10'd1023, 16'sh0000, 16'h0000);
        send_item(wbaa_pkg::OP_ACC, 10'd0, 16'sh0180, 16'h0100);
        send_item(wbaa_pkg::OP_ACC, 10'd0, -16'sh0100, 16'h0300);
        send_item(wbaa_pkg::OP_READ, 10'd0, 16'sh0000, 16'h0000);
        send_item(wbaa_pkg::OP_ACC, 10'd512, 16'sh7FFF, 16'h0001);
        send_item(wbaa_pkg::OP_READ, 10'd512, 16'sh0000, 16'h0000);
        send_item(wbaa_pkg::OP_ACC, 10'd513, -16'sd32768, 16'hFFFF);
        send_item(wbaa_pkg::OP_READ, 10'd513, 16'sh0000, 16'h0000);
        send_item(wbaa_pkg::OP_ACC, 10'd1, -16'sd1, 16'h0002);
        send_item(wbaa_pkg::OP_ACC, 10'd1, 16'sh0000, 16'h0001);
        send_item(wbaa_pkg::OP_READ, 10'd1, 16'sh0000, 16'h0000);
        send_item(wbaa_pkg::OP_ACC, 10'd2, -16'sd3, 16'h0001);
        send_item(wbaa_pkg::OP_ACC, 10'd2, 16'sh5555, 16'hAAAA);
        send_item(wbaa_pkg::OP_READ, 10'd2, 16'shAAAA, 16'h5555);
        wait_for_results();

        // Most traffic hits a small group of bins so that means build up over
        // many samples; the rest spreads over the whole table.
        hot_base = $urandom_range(0, wbaa_pkg::BIN_COUNT - 8);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 150 == 0)
                steady_stretch = ($urandom_range(0, 3) == 0);
            if (i == RANDOM_ITEMS / 2)
                wait_for_results();
            op = ($urandom_range(0, 99) < 55) ? wbaa_pkg::OP_ACC : wbaa_pkg::OP_READ;
            if ($urandom_range(0, 99) < 60)
                bin = wbaa_pkg::BIN_W'(hot_base + $urandom_range(0, 7));
            else
                bin = wbaa_pkg::BIN_W'($urandom_range(0, wbaa_pkg::BIN_COUNT - 1));
            if ($urandom_range(0, 9) == 0)
                value = $urandom_range(0, 1) ? 16'sh7FFF : -16'sd32768;
            else
                value = wbaa_pkg::VALUE_W'($urandom);
            case ($urandom_range(0, 19))
                0, 1:       weight = '0;
                2, 3, 4, 5: weight = 16'h0100;
                6:          weight = 16'hFFFF;
                default:    weight = wbaa_pkg::WEIGHT_W'($urandom);
            endcase
            send_item(op, bin, value, weight);
        end
        steady_stretch = 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d accumulates and %0d reads, %0d of the reads on empty bins",
                 sb.accumulates, sb.reads, sb.empty_reads);
        $display("tb: %0d mismatches, %0d bins in use at the end", sb.errors, sb.used_bins);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/wbaa_pkg.sv
rtl/wbaa_front.sv
rtl/wbaa_queue.sv
rtl/wbaa_div.sv
rtl/wbaa_back.sv
rtl/weighted_bin_average_accumulator.sv
test/tb_top.sv
